>>> src/lc3_instruction_execute_assert.svh
// assertion macros for the lc3 execute block
`ifndef LC3_INSTRUCTION_EXECUTE_ASSERT_SVH
`define LC3_INSTRUCTION_EXECUTE_ASSERT_SVH
// implication checked every clock outside reset
`define LC3_ASSERT_IMPL(label, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked every clock outside reset
`define LC3_ASSERT_NEXT(label, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> src/lc3_pkg.sv
// shared types and constants for the lc3 execute block
package lc3_pkg;
  localparam logic [1:0] OP_MEM_WRITE = 2'd0;
  localparam logic [1:0] OP_EXECUTE   = 2'd1;
  localparam logic [1:0] OP_SET_PC    = 2'd2;

  localparam logic [3:0] OPC_BR   = 4'd0;
  localparam logic [3:0] OPC_ADD  = 4'd1;
  localparam logic [3:0] OPC_LD   = 4'd2;
  localparam logic [3:0] OPC_ST   = 4'd3;
  localparam logic [3:0] OPC_JSR  = 4'd4;
  localparam logic [3:0] OPC_AND  = 4'd5;
  localparam logic [3:0] OPC_LDR  = 4'd6;
  localparam logic [3:0] OPC_STR  = 4'd7;
  localparam logic [3:0] OPC_RTI  = 4'd8;
  localparam logic [3:0] OPC_NOT  = 4'd9;
  localparam logic [3:0] OPC_LDI  = 4'd10;
  localparam logic [3:0] OPC_STI  = 4'd11;
  localparam logic [3:0] OPC_JMP  = 4'd12;
  localparam logic [3:0] OPC_RES  = 4'd13;
  localparam logic [3:0] OPC_LEA  = 4'd14;
  localparam logic [3:0] OPC_TRAP = 4'd15;

  localparam logic [7:0] TRAP_SVC_LO = 8'h20;
  localparam logic [7:0] TRAP_SVC_HI = 8'h25;

  // result item fields
  typedef struct packed {
    logic [15:0] pc;
    logic [2:0]  cond_codes;
    logic [15:0] dest_value;
    logic        trap_request;
    logic [7:0]  trap_vector;
    logic        exception_flag;
  } result_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RD1   = 5'b00010,
    ST_RD2   = 5'b00100,
    ST_WB    = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  function automatic logic [2:0] cc_of(input logic [15:0] v);
    if (v[15]) return 3'b100;
    else if (v == 16'd0) return 3'b010;
    else return 3'b001;
  endfunction
endpackage

>>> src/lc3_ram.sv
// generic single-port ram with registered read
module lc3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write one word and read one word a cycle
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> src/lc3_instruction_execute.sv
// lc3 instruction execute block: sequencer over a word memory
//
//  channel | dir | signals              | payload
//  s_axis  | in  | tvalid tready tdata  | operation instruction address data
//  m_axis  | out | tvalid tready tdata  | pc cond dest trap_req trap_vec exc
//
// register-only work ends in idle; an item with one memory access after the first
// (ld, ldr, sti, vectored trap) also passes rd1, one with two dependent reads (ldi,
// rti) rd1 and rd2, bound by the single memory port. the result sits in an output
// register; the next item is taken while it waits unless it is full and stalled. rst
// clears registers, pc and status word; the memory is not cleared.
module lc3_instruction_execute
  import lc3_pkg::*;
#(
  parameter int MEM_WORDS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation[1:0], instruction[17:2], address[33:18], data[49:34], zero fill
  input  logic [55:0] s_axis_tdata,
  input  logic        m_axis_tready,
  output logic        m_axis_tvalid,
  // pc[15:0], cond_codes[18:16], dest_value[34:19], trap_request[35],
  // trap_vector[43:36], exception_flag[44], zero fill
  output logic [47:0] m_axis_tdata
);
  localparam int AW = $clog2(MEM_WORDS);

  state_t state;
  logic [15:0] regs [8];
  logic [15:0] pc_r, psr;
  logic [15:0] ins;
  logic [15:0] t1;
  logic        out_valid;
  logic        out_valid_next;
  result_t     res;
  result_t     res_next;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [15:0]   mem_wdata, mem_rdata;

  lc3_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_mem (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  // input field split
  logic [1:0]  in_op;
  logic [15:0] in_ins, in_addr, in_data;
  assign in_op   = s_axis_tdata[1:0];
  assign in_ins  = s_axis_tdata[17:2];
  assign in_addr = s_axis_tdata[33:18];
  assign in_data = s_axis_tdata[49:34];

  logic accept;
  assign s_axis_tready = (state == ST_IDLE) && (!out_valid || m_axis_tready);
  assign accept = s_axis_tvalid && s_axis_tready;

  // decode from incoming word (idle) or held word
  logic [15:0] di;
  assign di = (state == ST_IDLE) ? in_ins : ins;
  logic [3:0]  opc;
  logic [2:0]  dr, sr1, sr2;
  logic [15:0] off9, off6, imm5, off11, bop, pc9, r6;
  logic [15:0] ldr_ea, sp_next1, alu_v, jsr_tg;
  assign opc   = di[15:12];
  assign dr    = di[11:9];
  assign sr1   = di[8:6];
  assign sr2   = di[2:0];
  assign off9  = {{7{di[8]}}, di[8:0]};
  assign off6  = {{10{di[5]}}, di[5:0]};
  assign imm5  = {{11{di[4]}}, di[4:0]};
  assign off11 = {{5{di[10]}}, di[10:0]};
  assign bop   = di[5] ? imm5 : regs[sr2];
  assign pc9   = pc_r + off9;
  assign r6    = regs[6];
  assign ldr_ea   = regs[sr1] + off6;
  assign sp_next1 = r6 + 16'd1;

  // register-only results and jump target
  assign alu_v  = (opc == OPC_ADD) ? regs[sr1] + bop :
                  (opc == OPC_AND) ? regs[sr1] & bop :
                  (opc == OPC_NOT) ? ~regs[sr1] : pc9;
  assign jsr_tg = di[11] ? pc_r + off11 : regs[sr1];

  logic svc;
  assign svc = (di[7:0] >= TRAP_SVC_LO) && (di[7:0] <= TRAP_SVC_HI);

  // memory port selection
  always_comb begin
    mem_we = 1'b0;
    mem_addr = in_addr[AW-1:0];
    mem_wdata = in_data;
    case (state)
      ST_IDLE: begin
        if (accept && in_op == OP_MEM_WRITE) mem_we = 1'b1;
        else if (accept && in_op == OP_EXECUTE) begin
          mem_wdata = regs[dr];
          case (opc)
            OPC_LD, OPC_LDI, OPC_STI: mem_addr = pc9[AW-1:0];
            OPC_ST: begin mem_addr = pc9[AW-1:0]; mem_we = 1'b1; end
            OPC_LDR: mem_addr = ldr_ea[AW-1:0];
            OPC_STR: begin
              mem_addr = ldr_ea[AW-1:0];
              mem_we = 1'b1;
            end
            OPC_RTI: mem_addr = r6[AW-1:0];
            OPC_TRAP: mem_addr = AW'(di[7:0]);
            default: ;
          endcase
        end
      end
      ST_RD1: begin
        mem_wdata = regs[dr];
        case (opc)
          OPC_LDI: mem_addr = mem_rdata[AW-1:0];
          OPC_STI: begin mem_addr = mem_rdata[AW-1:0]; mem_we = 1'b1; end
          OPC_RTI: mem_addr = sp_next1[AW-1:0];
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // next result item and its valid flag
  always_comb begin
    res_next = res;
    out_valid_next = out_valid && !m_axis_tready;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          res_next = '0;
          res_next.pc = pc_r;
          res_next.cond_codes = psr[2:0];
          out_valid_next = 1'b1;
          if (in_op == OP_SET_PC) res_next.pc = in_addr;
          else if (in_op == OP_EXECUTE) begin
            case (opc)
              OPC_BR: if ((dr & psr[2:0]) != 3'd0) res_next.pc = pc9;
              OPC_ADD, OPC_AND, OPC_NOT, OPC_LEA: begin
                res_next.cond_codes = cc_of(alu_v);
                res_next.dest_value = alu_v;
              end
              OPC_JSR: begin
                res_next.dest_value = pc_r;
                res_next.pc = jsr_tg;
              end
              OPC_JMP: res_next.pc = regs[sr1];
              OPC_RES: res_next.exception_flag = 1'b1;
              OPC_RTI: begin
                if (psr[15]) res_next.exception_flag = 1'b1;
                else out_valid_next = 1'b0;
              end
              OPC_TRAP: begin
                res_next.dest_value = pc_r;
                res_next.trap_vector = di[7:0];
                if (svc) res_next.trap_request = 1'b1;
                else out_valid_next = 1'b0;
              end
              OPC_LD, OPC_LDR, OPC_LDI, OPC_STI: out_valid_next = 1'b0;
              default: ;
            endcase
          end
        end
      end
      ST_RD1: begin
        case (opc)
          OPC_LD, OPC_LDR: begin
            res_next.cond_codes = cc_of(mem_rdata);
            res_next.dest_value = mem_rdata;
            out_valid_next = 1'b1;
          end
          OPC_TRAP: begin
            res_next.pc = mem_rdata;
            out_valid_next = 1'b1;
          end
          OPC_STI: out_valid_next = 1'b1;
          default: ;
        endcase
      end
      ST_RD2: begin
        if (opc == OPC_LDI) begin
          res_next.cond_codes = cc_of(mem_rdata);
          res_next.dest_value = mem_rdata;
        end else begin
          res_next.pc = t1;
          res_next.cond_codes = mem_rdata[2:0];
          res_next.dest_value = r6 + 16'd2;
        end
        out_valid_next = 1'b1;
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {3'd0, res.exception_flag, res.trap_vector, res.trap_request,
                         res.dest_value, res.cond_codes, res.pc};

  // sequencer, register file and result register
  always_ff @(posedge clk) begin
    res <= res_next;
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      pc_r <= 16'd0;
      psr <= 16'd0;
      for (int i = 0; i < 8; i++) regs[i] <= 16'd0;
    end else begin
      out_valid <= out_valid_next;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            ins <= in_ins;
            if (in_op == OP_SET_PC) begin
              pc_r <= in_addr;
            end else if (in_op == OP_EXECUTE) begin
              case (opc)
                OPC_BR: if ((dr & psr[2:0]) != 3'd0) pc_r <= pc9;
                OPC_ADD, OPC_AND, OPC_NOT, OPC_LEA: begin
                  regs[dr] <= alu_v;
                  psr[2:0] <= cc_of(alu_v);
                end
                OPC_JSR: begin
                  regs[7] <= pc_r;
                  pc_r <= jsr_tg;
                end
                OPC_JMP: pc_r <= regs[sr1];
                OPC_RTI: if (!psr[15]) state <= ST_RD1;
                OPC_TRAP: begin
                  regs[7] <= pc_r;
                  if (!svc) state <= ST_RD1;
                end
                OPC_LD, OPC_LDR, OPC_LDI, OPC_STI: state <= ST_RD1;
                default: ;
              endcase
            end
          end
        end
        ST_RD1: begin
          t1 <= mem_rdata;
          case (opc)
            OPC_LD, OPC_LDR: begin
              regs[dr] <= mem_rdata;
              psr[2:0] <= cc_of(mem_rdata);
              state <= ST_IDLE;
            end
            OPC_TRAP: begin
              pc_r <= mem_rdata;
              state <= ST_IDLE;
            end
            OPC_STI: state <= ST_IDLE;
            default: state <= ST_RD2;
          endcase
        end
        ST_RD2: begin
          if (opc == OPC_LDI) begin
            regs[dr] <= mem_rdata;
            psr[2:0] <= cc_of(mem_rdata);
          end else begin
            pc_r <= t1;
            psr <= mem_rdata;
            regs[6] <= r6 + 16'd2;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

>>> src/lc3_checker.sv
// port-level checker for the lc3 execute block, bound to the top level
`include "lc3_instruction_execute_assert.svh"
module lc3_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);
  // a stalled result holds its payload
  `LC3_ASSERT_NEXT(a_hold, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && m_axis_tvalid, "result changed under stall")
  // no item accepted while a full result is stalled
  `LC3_ASSERT_IMPL(a_nopush, rst, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken over a stalled result")
  // trap request never comes with an exception
  `LC3_ASSERT_IMPL(a_excl, rst, m_axis_tvalid, !(m_axis_tdata[35] && m_axis_tdata[44]), "trap and exception together")
  // an exception writes no register
  `LC3_ASSERT_IMPL(a_excdv, rst, m_axis_tvalid && m_axis_tdata[44], m_axis_tdata[34:19] == 16'd0, "exception with a destination value")
endmodule

bind lc3_instruction_execute lc3_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

>>> bench/tb_lc3_instruction_execute.sv
// self-checking testbench for the lc3 instruction execute block
module tb_lc3_instruction_execute;
  import lc3_pkg::*;

  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int N_RANDOM = 1250;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tready = 1'b0;
  logic        m_axis_tvalid;
  logic [47:0] m_axis_tdata;

  lc3_instruction_execute DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tready(m_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk = ~clk;

  // predictor state: registers, pc, status word and the words written so far
  logic [15:0] gpr [8];
  logic [15:0] cur_pc;
  logic [15:0] psr;
  logic [15:0] mem_words [int];
  bit          allow_user;

  logic [55:0] pending_items [$];
  result_t     expected_results [$];
  int          n_errors;
  int          n_results;
  int          n_items;
  int          n_exec;
  int          n_traps;
  int          n_exceptions;
  longint      cycles;
  bit          s_fire;

  function automatic logic [2:0] flags_of(input logic [15:0] v);
    if (v[15]) return 3'b100;
    if (v == 16'd0) return 3'b010;
    return 3'b001;
  endfunction

  function automatic logic [15:0] sx(input logic [15:0] v, input int bits);
    logic [15:0] m;
    m = (16'd1 << bits) - 16'd1;
    v = v & m;
    if (v[bits-1]) v = v | ~m;
    return v;
  endfunction

  // first memory read this instruction would make of a word never written, else -1
  function automatic int unwritten_read(input logic [15:0] ins);
    logic [15:0] a;
    logic [3:0]  opc;
    opc = ins[15:12];
    case (opc)
      OPC_LD, OPC_LDI, OPC_STI: begin
        a = cur_pc + sx(ins, 9);
        if (!mem_words.exists(a)) return int'(a);
        if (opc == OPC_LDI && !mem_words.exists(mem_words[a])) return int'(mem_words[a]);
      end
      OPC_LDR: begin
        a = gpr[ins[8:6]] + sx(ins, 6);
        if (!mem_words.exists(a)) return int'(a);
      end
      OPC_RTI: begin
        if (!psr[15]) begin
          if (!mem_words.exists(gpr[6])) return int'(gpr[6]);
          a = gpr[6] + 16'd1;
          if (!mem_words.exists(a)) return int'(a);
        end
      end
      OPC_TRAP: begin
        a = {8'd0, ins[7:0]};
        if ((ins[7:0] < TRAP_SVC_LO || ins[7:0] > TRAP_SVC_HI) && !mem_words.exists(a))
          return int'(a);
      end
      default: ;
    endcase
    return -1;
  endfunction

  // update predictor state for one item and queue the item with its result
  task automatic apply_item(input logic [1:0] op, input logic [15:0] ins,
                            input logic [15:0] addr, input logic [15:0] data);
    result_t     r;
    logic [15:0] b, t, sp, pcv, dv;
    logic [2:0]  dr, sr1;
    r = '0;
    dv = 16'd0;
    dr = ins[11:9];
    sr1 = ins[8:6];
    pcv = cur_pc;
    b = ins[5] ? sx(ins, 5) : gpr[ins[2:0]];
    if (op == OP_MEM_WRITE) mem_words[addr] = data;
    else if (op == OP_SET_PC) cur_pc = addr;
    else if (op == OP_EXECUTE) begin
      n_exec++;
      case (ins[15:12])
        OPC_BR: if (ins[11:9] & psr[2:0]) cur_pc = pcv + sx(ins, 9);
        OPC_ADD: dv = gpr[sr1] + b;
        OPC_AND: dv = gpr[sr1] & b;
        OPC_NOT: dv = ~gpr[sr1];
        OPC_LEA: dv = pcv + sx(ins, 9);
        OPC_LD: dv = mem_words[16'(pcv + sx(ins, 9))];
        OPC_LDR: dv = mem_words[16'(gpr[sr1] + sx(ins, 6))];
        OPC_LDI: dv = mem_words[mem_words[16'(pcv + sx(ins, 9))]];
        OPC_ST: mem_words[16'(pcv + sx(ins, 9))] = gpr[dr];
        OPC_STR: mem_words[16'(gpr[sr1] + sx(ins, 6))] = gpr[dr];
        OPC_STI: mem_words[mem_words[16'(pcv + sx(ins, 9))]] = gpr[dr];
        OPC_JMP: cur_pc = gpr[sr1];
        OPC_JSR: begin
          // target taken before r7 is overwritten
          t = ins[11] ? pcv + sx(ins, 11) : gpr[sr1];
          gpr[7] = pcv;
          dv = pcv;
          cur_pc = t;
        end
        OPC_RTI: begin
          if (psr[15]) r.exception_flag = 1'b1;
          else begin
            sp = gpr[6];
            cur_pc = mem_words[sp];
            psr = mem_words[16'(sp + 16'd1)];
            gpr[6] = sp + 16'd2;
            dv = gpr[6];
          end
        end
        OPC_RES: r.exception_flag = 1'b1;
        default: begin
          // trap: service vectors raise a request, vectored ones jump
          r.trap_vector = ins[7:0];
          gpr[7] = pcv;
          dv = pcv;
          if (ins[7:0] >= TRAP_SVC_LO && ins[7:0] <= TRAP_SVC_HI) r.trap_request = 1'b1;
          else cur_pc = mem_words[{8'd0, ins[7:0]}];
        end
      endcase
      // register writes with condition codes
      if (ins[15:12] inside {OPC_ADD, OPC_AND, OPC_NOT, OPC_LEA, OPC_LD, OPC_LDR, OPC_LDI}) begin
        gpr[dr] = dv;
        psr[2:0] = flags_of(dv);
      end
    end
    r.pc = cur_pc;
    r.cond_codes = psr[2:0];
    r.dest_value = dv;
    expected_results.push_back(r);
    pending_items.push_back({6'd0, data, addr, ins, op});
  endtask

  // issue an item, first writing any memory word it would read unwritten
  task automatic issue(input logic [1:0] op, input logic [15:0] ins,
                       input logic [15:0] addr, input logic [15:0] data);
    int a;
    if (op == OP_EXECUTE && ins[15:12] == OPC_RTI && !psr[15] && !allow_user)
      apply_item(OP_MEM_WRITE, 16'($urandom), gpr[6] + 16'd1, 16'($urandom) & 16'h7FFF);
    if (op == OP_EXECUTE) begin
      a = unwritten_read(ins);
      while (a >= 0) begin
        apply_item(OP_MEM_WRITE, 16'($urandom), 16'(a), 16'($urandom));
        a = unwritten_read(ins);
      end
    end
    apply_item(op, ins, addr, data);
  endtask

  task automatic run_exec(input logic [15:0] ins);
    issue(OP_EXECUTE, ins, 16'($urandom), 16'($urandom));
  endtask

  task automatic random_item();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 12) issue(OP_MEM_WRITE, 16'($urandom), 16'($urandom), 16'($urandom));
    else if (sel < 20) issue(OP_SET_PC, 16'($urandom), 16'($urandom), 16'($urandom));
    else if (sel < 24) issue(OP_NOP, 16'($urandom), 16'($urandom), 16'($urandom));
    else run_exec(16'($urandom));
  endtask

  // stimulus and end of run
  initial begin
    int i;
    foreach (gpr[k]) gpr[k] = 16'd0;
    cur_pc = 16'd0;
    psr = 16'd0;
    allow_user = 1'b0;
    n_errors = 0;
    // directed part
    run_exec(16'h0E05);                 // branch right after reset: not taken
    run_exec(16'h1230);                 // add, most negative immediate
    run_exec(16'h126F);                 // add, largest immediate
    run_exec(16'h5481);                 // and with register
    run_exec(16'h967F);                 // not
    run_exec(16'h0E05);                 // branch taken
    issue(OP_SET_PC, 16'h0, 16'hFFF0, 16'h0);
    run_exec(16'hE81F);                 // lea wraps past the top
    run_exec(16'h2A1F);                 // ld wraps
    run_exec(16'h3700);                 // st
    run_exec(16'h6D20);                 // ldr
    run_exec(16'h771F);                 // str
    run_exec(16'hA1FF);                 // ldi
    run_exec(16'hB200);                 // sti
    run_exec(16'h4BFF);                 // jsr forward
    run_exec(16'h4C00);                 // jsr backward
    run_exec(16'h41C0);                 // jsrr through r7
    run_exec(16'hC100);                 // jmp
    run_exec(16'hD000);                 // reserved opcode
    run_exec(16'h8000);                 // rti in supervisor mode
    run_exec(16'hF020);                 // service traps
    run_exec(16'hF025);
    run_exec(16'hF01F);                 // vectored traps
    run_exec(16'hF0FF);
    issue(OP_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue(OP_MEM_WRITE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (i = 0; i < N_RANDOM; i++) random_item();
    // user mode: popped status word has the mode bit set, then rti faults
    allow_user = 1'b1;
    issue(OP_MEM_WRITE, 16'h0, gpr[6] + 16'd1, 16'h8005);
    run_exec(16'h8000);
    run_exec(16'h8000);
    run_exec(16'hDFFF);
    n_items = pending_items.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait (pending_items.size() == 0 && !s_axis_tvalid);
    wait (expected_results.size() == 0);
    repeat (10) @(posedge clk);
    $display("ran %0d items, %0d instructions, %0d results checked", n_items, n_exec, n_results);
    $display("traps seen %0d, exceptions seen %0d", n_traps, n_exceptions);
    if (n_errors == 0) $display("lc3_instruction_execute regression: pass");
    else $display("lc3_instruction_execute regression: fail");
    $finish;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("lc3_instruction_execute regression: fail");
      $finish;
    end
  end
  initial cycles = 0;

  // input item handshake seen at the rising edge
  always @(posedge clk) begin
    s_fire <= !rst && s_axis_tvalid && s_axis_tready;
  end

  // driver: new item at a falling edge after the previous one was taken, with random gaps
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_fire) begin
      if (s_fire) begin
        case ($urandom_range(0, 9))
          0: gap_left = $urandom_range(5, 30);
          1, 2, 3: gap_left = $urandom_range(1, 3);
          default: gap_left = 0;
        endcase
      end
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        s_axis_tdata <= pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready: random stalls and one long hold-off
  int  hold_left = 0;
  bit  long_hold_done = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!long_hold_done && n_results > 400) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0: begin
          hold_left = $urandom_range(5, 30);
          m_axis_tready <= 1'b0;
        end
        1, 2, 3, 4: m_axis_tready <= 1'b0;
        default: m_axis_tready <= 1'b1;
      endcase
    end
  end

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
    end
  endtask

  // monitor: compare each result item with the oldest expectation
  always @(posedge clk) begin
    result_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (m_axis_tdata[35]) n_traps++;
      if (m_axis_tdata[44]) n_exceptions++;
      if (expected_results.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, expected none, actual %h", $realtime, m_axis_tdata);
      end else begin
        e = expected_results.pop_front();
        check_field("pc", e.pc, m_axis_tdata[15:0]);
        check_field("cond_codes", 16'(e.cond_codes), 16'(m_axis_tdata[18:16]));
        check_field("dest_value", e.dest_value, m_axis_tdata[34:19]);
        check_field("trap_request", 16'(e.trap_request), 16'(m_axis_tdata[35]));
        check_field("trap_vector", 16'(e.trap_vector), 16'(m_axis_tdata[43:36]));
        check_field("exception_flag", 16'(e.exception_flag), 16'(m_axis_tdata[44]));
      end
    end
  end
  initial n_results = 0;
  initial n_traps = 0;
  initial n_exceptions = 0;
  initial n_exec = 0;
endmodule

>>> sim.f
+incdir+src
src/lc3_pkg.sv
src/lc3_ram.sv
src/lc3_instruction_execute.sv
src/lc3_checker.sv
bench/tb_lc3_instruction_execute.sv
